// ===== rtl/fdpr_pkg.sv =====
// ----------------------------------------------------------------------------
// fdpr_pkg
// Types, codes and constants shared by the drive phase register model.
// ----------------------------------------------------------------------------
package fdpr_pkg;

    localparam int unsigned LAST_TRACK  = 79;
    localparam int unsigned TRACK_W     = 7;
    localparam int unsigned PHASE_W     = 4;
    localparam int unsigned ADDR_W      = 4;

    typedef enum logic [2:0] {
        MODE_PHASE_WRITE = 3'd0,
        MODE_SENSE_READ  = 3'd1,
        MODE_MOTOR_LINE  = 3'd2,
        MODE_HEAD_LINE   = 3'd3,
        MODE_SELECT_LINE = 3'd4,
        MODE_MEDIA_CHG   = 3'd5
    } mode_t;

    // register addresses {select line, phase bits 2..0}
    localparam logic [ADDR_W-1:0] REG_DIR_IN     = 4'h0;
    localparam logic [ADDR_W-1:0] REG_STEP       = 4'h1;
    localparam logic [ADDR_W-1:0] REG_MOTOR_ON   = 4'h2;
    localparam logic [ADDR_W-1:0] REG_MOTOR_OFF  = 4'h3;
    localparam logic [ADDR_W-1:0] REG_EJECT      = 4'h4;
    localparam logic [ADDR_W-1:0] REG_HEAD0      = 4'h8;
    localparam logic [ADDR_W-1:0] REG_HEAD1      = 4'h9;
    localparam logic [ADDR_W-1:0] REG_READY      = 4'hA;
    localparam logic [ADDR_W-1:0] REG_DISK_IN    = 4'hB;
    localparam logic [ADDR_W-1:0] REG_SELECT     = 4'hD;
    localparam logic [ADDR_W-1:0] REG_PRESENT    = 4'hF;

    // sense address aliases
    localparam logic [ADDR_W-1:0] REG_TRACK0     = REG_MOTOR_OFF;
    localparam logic [ADDR_W-1:0] REG_SWITCHED   = REG_EJECT;
    localparam logic [ADDR_W-1:0] REG_SIDES      = REG_HEAD0;

    typedef struct packed {
        logic [2:0]         mode;
        logic [PHASE_W-1:0] phase_bits;
        logic               line_level;
        logic               disk_loaded;
    } cmd_t;

    typedef struct packed {
        logic sense;
        logic eject_request;
    } rsp_t;

endpackage

// ===== rtl/fdpr_cmd_if.sv =====
// ----------------------------------------------------------------------------
// fdpr_cmd_if
// Command channel: valid/ready handshake with the input item fields.
// ----------------------------------------------------------------------------
interface fdpr_cmd_if;

    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [3:0] phase_bits;
    logic       line_level;
    logic       disk_loaded;

    modport source (
        output valid, mode, phase_bits, line_level, disk_loaded,
        input  ready
    );

    modport sink (
        input  valid, mode, phase_bits, line_level, disk_loaded,
        output ready
    );

endinterface

// ===== rtl/fdpr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// fdpr_rsp_if
// Response channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface fdpr_rsp_if;

    logic valid;
    logic ready;
    logic sense;
    logic eject_request;

    modport source (
        output valid, sense, eject_request,
        input  ready
    );

    modport sink (
        input  valid, sense, eject_request,
        output ready
    );

endinterface

// ===== rtl/floppy_drive_phase_register_model_unit.sv =====
// ----------------------------------------------------------------------------
// floppy_drive_phase_register_model_unit
// Phase-line command interface of a 3.5 inch floppy drive.
//
//   channel  modport  moves per transaction
//   cmd      sink     mode, phase_bits, line_level, disk_loaded
//   rsp      source   sense, eject_request
//
// One transaction per cycle sustained unless rsp stalls; cmd passes the
// input register, then the result register. The drive state updates
// when a command moves from the input register into the result register.
// A stalled rsp holds the result; cmd stays ready while the input register
// can drain. Reset clears valid flags and drive state; direction is inward.
// ----------------------------------------------------------------------------
module floppy_drive_phase_register_model_unit #(
    parameter int unsigned LastTrack = fdpr_pkg::LAST_TRACK
) (
    input  logic       clk,
    input  logic       rst_n,
    fdpr_cmd_if.sink   cmd,
    fdpr_rsp_if.source rsp
);

    import fdpr_pkg::*;

    cmd_t cmd_reg;
    logic cmd_valid_reg;
    rsp_t rsp_reg;
    logic rsp_valid_reg;
    rsp_t rsp_next;
    logic advance;

    assign advance   = cmd_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign cmd.ready = !cmd_valid_reg || advance;

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.sense         = rsp_reg.sense;
    assign rsp.eject_request = rsp_reg.eject_request;

    fdpr_engine #(
        .LastTrack (LastTrack)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .cmd   (cmd_reg),
        .rsp   (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ready)
                cmd_valid_reg <= cmd.valid;
            if (advance)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            cmd_reg.mode        <= cmd.mode;
            cmd_reg.phase_bits  <= cmd.phase_bits;
            cmd_reg.line_level  <= cmd.line_level;
            cmd_reg.disk_loaded <= cmd.disk_loaded;
        end
        if (advance)
            rsp_reg <= rsp_next;
    end

endmodule

// ===== rtl/fdpr_engine.sv =====
// ----------------------------------------------------------------------------
// fdpr_engine
// Drive state registers with the phase strobe decode and the sense mux.
// ----------------------------------------------------------------------------
module fdpr_engine #(
    parameter int unsigned LastTrack = fdpr_pkg::LAST_TRACK
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  fdpr_pkg::cmd_t cmd,
    output fdpr_pkg::rsp_t rsp
);

    import fdpr_pkg::*;

    localparam logic [TRACK_W-1:0] TrackMax = TRACK_W'(LastTrack);

    logic [PHASE_W-1:0] phase_latch_reg, phase_latch_next;
    logic               motor_running_reg, motor_running_next;
    logic               upper_head_reg, upper_head_next;
    logic               select_line_reg, select_line_next;
    logic               direction_inward_reg, direction_inward_next;
    logic               switched_latch_reg, switched_latch_next;
    logic [TRACK_W-1:0] head_track_reg, head_track_next;

    logic              strobe;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              sense_bit;

    assign wr_addr = {select_line_reg, cmd.phase_bits[2:0]};
    assign rd_addr = {select_line_reg, phase_latch_reg[2:0]};
    assign strobe  = !phase_latch_reg[3] && cmd.phase_bits[3];

    always_comb
    begin
        phase_latch_next      = phase_latch_reg;
        motor_running_next    = motor_running_reg;
        upper_head_next       = upper_head_reg;
        select_line_next      = select_line_reg;
        direction_inward_next = direction_inward_reg;
        switched_latch_next   = switched_latch_reg;
        head_track_next       = head_track_reg;
        rsp.sense             = 1'b1;
        rsp.eject_request     = 1'b0;
        sense_bit             = 1'b1;

        unique case (rd_addr)
            REG_DIR_IN:   sense_bit = !direction_inward_reg;
            REG_TRACK0:   sense_bit = (head_track_reg != '0);
            REG_MOTOR_ON: sense_bit = !motor_running_reg;
            REG_SWITCHED: sense_bit = !switched_latch_reg;
            REG_SIDES:    sense_bit = 1'b0;
            REG_READY:    sense_bit = !(cmd.disk_loaded && motor_running_reg);
            REG_DISK_IN:  sense_bit = !cmd.disk_loaded;
            REG_SELECT:   sense_bit = !select_line_reg;
            REG_PRESENT:  sense_bit = 1'b0;
            default:      sense_bit = 1'b1;
        endcase

        unique case (cmd.mode)
            MODE_PHASE_WRITE:
            begin
                phase_latch_next = cmd.phase_bits;
                if (strobe)
                begin
                    unique case (wr_addr)
                        REG_DIR_IN:    direction_inward_next = 1'b1;
                        REG_STEP:
                        begin
                            if (direction_inward_reg)
                            begin
                                if (head_track_reg != '0)
                                    head_track_next = head_track_reg - 1'b1;
                            end
                            else if (head_track_reg < TrackMax)
                            begin
                                head_track_next = head_track_reg + 1'b1;
                            end
                        end
                        REG_MOTOR_ON:  motor_running_next = 1'b1;
                        REG_MOTOR_OFF: motor_running_next = 1'b0;
                        REG_EJECT:
                        begin
                            if (cmd.disk_loaded)
                            begin
                                switched_latch_next = 1'b1;
                                rsp.eject_request   = 1'b1;
                            end
                        end
                        REG_HEAD0:     upper_head_next = 1'b0;
                        REG_HEAD1:     upper_head_next = 1'b1;
                        default:       ;
                    endcase
                end
            end
            MODE_SENSE_READ:
            begin
                rsp.sense = sense_bit;
                if (rd_addr == REG_SWITCHED)
                    switched_latch_next = 1'b0;
            end
            MODE_MOTOR_LINE:  motor_running_next = !cmd.line_level;
            MODE_HEAD_LINE:   upper_head_next    = cmd.line_level;
            MODE_SELECT_LINE: select_line_next   = cmd.line_level;
            MODE_MEDIA_CHG:   switched_latch_next = 1'b1;
            default:          ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_latch_reg      <= '0;
            motor_running_reg    <= 1'b0;
            upper_head_reg       <= 1'b0;
            select_line_reg      <= 1'b0;
            direction_inward_reg <= 1'b1;
            switched_latch_reg   <= 1'b0;
            head_track_reg       <= '0;
        end
        else if (fire)
        begin
            phase_latch_reg      <= phase_latch_next;
            motor_running_reg    <= motor_running_next;
            upper_head_reg       <= upper_head_next;
            select_line_reg      <= select_line_next;
            direction_inward_reg <= direction_inward_next;
            switched_latch_reg   <= switched_latch_next;
            head_track_reg       <= head_track_next;
        end
    end

endmodule

// ===== tb/sv/floppy_drive_phase_register_model_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// floppy_drive_phase_register_model_unit_tb
// Self-checking bench for the drive phase register model. Directed checks
// cover strobe edges, every command, eject, media change and the switched
// latch. Random command sequences then run under several sender and receiver
// idle mixes and one long response hold. Every response is compared with a
// model of the drive state kept in the bench.
// ----------------------------------------------------------------------------
module floppy_drive_phase_register_model_unit_tb;

    import fdpr_pkg::*;

    localparam logic [2:0] MODE_UNUSED6 = 3'd6;
    localparam logic [2:0] MODE_UNUSED7 = 3'd7;

    logic clk;
    logic rst_n;

    fdpr_cmd_if cmd_bus ();
    fdpr_rsp_if rsp_bus ();

    floppy_drive_phase_register_model_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    // drive state mirror
    logic [PHASE_W-1:0] st_phase;
    logic               st_motor;
    logic               st_upper_head;
    logic               st_select;
    logic               st_dir_in;
    logic               st_switched;
    logic [TRACK_W-1:0] st_track;

    rsp_t rsp_due[$];
    int   mismatches = 0;
    int   items_sent = 0;
    int   send_idle_pct = 0;
    int   rsp_stall_pct = 0;
    int   hold_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic rsp_t drive_response(input cmd_t c);
        rsp_t              r;
        logic [ADDR_W-1:0] addr;
        logic              strobe_rise;
        r.sense         = 1'b1;
        r.eject_request = 1'b0;
        case (c.mode)
            MODE_PHASE_WRITE:
            begin
                strobe_rise = !st_phase[3] && c.phase_bits[3];
                st_phase    = c.phase_bits;
                addr        = {st_select, st_phase[2:0]};
                if (strobe_rise)
                begin
                    case (addr)
                        REG_DIR_IN:    st_dir_in = 1'b1;
                        REG_STEP:
                        begin
                            if (st_dir_in)
                            begin
                                if (st_track != 0)
                                    st_track = st_track - 1'b1;
                            end
                            else if (st_track < LAST_TRACK)
                                st_track = st_track + 1'b1;
                        end
                        REG_MOTOR_ON:  st_motor = 1'b1;
                        REG_MOTOR_OFF: st_motor = 1'b0;
                        REG_EJECT:
                        begin
                            if (c.disk_loaded)
                            begin
                                st_switched     = 1'b1;
                                r.eject_request = 1'b1;
                            end
                        end
                        REG_HEAD0:     st_upper_head = 1'b0;
                        REG_HEAD1:     st_upper_head = 1'b1;
                        default:       ;
                    endcase
                end
            end
            MODE_SENSE_READ:
            begin
                addr = {st_select, st_phase[2:0]};
                case (addr)
                    REG_DIR_IN:   r.sense = !st_dir_in;
                    REG_MOTOR_ON: r.sense = !st_motor;
                    REG_TRACK0:   r.sense = (st_track != 0);
                    REG_SWITCHED:
                    begin
                        if (st_switched)
                        begin
                            st_switched = 1'b0;
                            r.sense     = 1'b0;
                        end
                    end
                    REG_SIDES:    r.sense = 1'b0;
                    REG_READY:    r.sense = !(c.disk_loaded && st_motor);
                    REG_DISK_IN:  r.sense = !c.disk_loaded;
                    REG_SELECT:   r.sense = !st_select;
                    REG_PRESENT:  r.sense = 1'b0;
                    default:      r.sense = 1'b1;
                endcase
            end
            MODE_MOTOR_LINE:  st_motor = !c.line_level;
            MODE_HEAD_LINE:   st_upper_head = c.line_level;
            MODE_SELECT_LINE: st_select = c.line_level;
            MODE_MEDIA_CHG:   st_switched = 1'b1;
            default:          ;
        endcase
        return r;
    endfunction

    // response checker and ready generator
    initial
    begin : rsp_check
        rsp_t got;
        rsp_t want;
        forever
        begin
            @(posedge clk);
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                got.sense         = rsp_bus.sense;
                got.eject_request = rsp_bus.eject_request;
                if (rsp_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transaction: sense=%0b eject_request=%0b",
                                 got.sense, got.eject_request);
                end
                else
                begin
                    want = rsp_due.pop_front();
                    if (got.sense !== want.sense || got.eject_request !== want.eject_request)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp sense=%0b eject=%0b, got sense=%0b eject=%0b",
                                     want.sense, want.eject_request,
                                     got.sense, got.eject_request);
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end
            else
                rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    task automatic send_cmd(input logic [2:0] mode, input logic [3:0] phase,
                            input logic level, input logic loaded);
        cmd_t item;
        item.mode        = mode;
        item.phase_bits  = phase;
        item.line_level  = level;
        item.disk_loaded = loaded;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_bus.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_bus.valid       <= 1'b1;
        cmd_bus.mode        <= mode;
        cmd_bus.phase_bits  <= phase;
        cmd_bus.line_level  <= level;
        cmd_bus.disk_loaded <= loaded;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        rsp_due.push_back(drive_response(item));
        items_sent++;
    endtask

    task automatic phase_write(input logic [3:0] phase, input logic loaded);
        send_cmd(MODE_PHASE_WRITE, phase, 1'b0, loaded);
    endtask

    task automatic sense_read(input logic loaded);
        send_cmd(MODE_SENSE_READ, 4'h0, 1'b0, loaded);
    endtask

    task automatic wait_responses();
        cmd_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (rsp_due.size() != 0);
    endtask

    task automatic random_sequence();
        int         kind;
        logic       loaded;
        logic [3:0] addr;
        kind   = $urandom_range(9);
        loaded = 1'($urandom_range(1));
        addr   = 4'($urandom_range(15));
        if (kind <= 5)
        begin
            if ($urandom_range(1))
                send_cmd(MODE_SELECT_LINE, 4'($urandom_range(15)), addr[3], loaded);
            send_cmd(MODE_PHASE_WRITE, {1'b0, addr[2:0]}, 1'($urandom_range(1)), loaded);
            send_cmd(MODE_PHASE_WRITE, {1'b1, addr[2:0]}, 1'($urandom_range(1)), loaded);
            if ($urandom_range(1))
                send_cmd(MODE_SENSE_READ, 4'($urandom_range(15)), 1'($urandom_range(1)),
                         1'($urandom_range(1)));
        end
        else if (kind <= 7)
        begin
            if ($urandom_range(1))
                send_cmd(MODE_SELECT_LINE, 4'($urandom_range(15)), addr[3], loaded);
            send_cmd(MODE_PHASE_WRITE, {1'($urandom_range(1)), addr[2:0]},
                     1'($urandom_range(1)), loaded);
            send_cmd(MODE_SENSE_READ, 4'($urandom_range(15)), 1'($urandom_range(1)),
                     loaded);
        end
        else if (kind == 8)
        begin
            case ($urandom_range(2))
                0:
                    send_cmd(MODE_MOTOR_LINE, 4'($urandom_range(15)),
                             1'($urandom_range(1)), loaded);
                1:
                    send_cmd(MODE_HEAD_LINE, 4'($urandom_range(15)),
                             1'($urandom_range(1)), loaded);
                default:
                    send_cmd(MODE_MEDIA_CHG, 4'($urandom_range(15)),
                             1'($urandom_range(1)), loaded);
            endcase
        end
        else
            send_cmd(3'($urandom_range(7)), 4'($urandom_range(15)),
                     1'($urandom_range(1)), loaded);
    endtask

    task automatic test_reset_state();
        sense_read(1'b1);
        wait_responses();
    endtask

    task automatic test_strobe_commands();
        phase_write(4'h1, 1'b1);
        phase_write(4'h9, 1'b1);   // step while already at track 0
        phase_write(4'h3, 1'b1);
        sense_read(1'b1);
        phase_write(4'hB, 1'b1);
        phase_write(4'h2, 1'b0);
        phase_write(4'hA, 1'b0);
        phase_write(4'hA, 1'b0);   // strobe held high, no command
        sense_read(1'b0);
        wait_responses();
    endtask

    task automatic test_eject_and_switched();
        phase_write(4'h4, 1'b0);
        phase_write(4'hC, 1'b0);   // no disk, eject ignored
        phase_write(4'h4, 1'b1);
        phase_write(4'hC, 1'b1);
        sense_read(1'b1);
        sense_read(1'b1);
        send_cmd(MODE_MEDIA_CHG, 4'h0, 1'b0, 1'b1);
        sense_read(1'b1);
        wait_responses();
    endtask

    task automatic test_select_and_heads();
        send_cmd(MODE_SELECT_LINE, 4'h0, 1'b1, 1'b1);
        phase_write(4'h0, 1'b1);
        phase_write(4'h8, 1'b1);
        phase_write(4'h1, 1'b1);
        phase_write(4'h9, 1'b1);
        phase_write(4'h7, 1'b1);
        phase_write(4'hF, 1'b1);   // unmapped address
        sense_read(1'b1);
        wait_responses();
    endtask

    task automatic test_lines_and_unused_modes();
        send_cmd(MODE_UNUSED6, 4'hF, 1'b1, 1'b1);
        send_cmd(MODE_UNUSED7, 4'hF, 1'b1, 1'b1);
        send_cmd(MODE_HEAD_LINE, 4'h0, 1'b1, 1'b0);
        send_cmd(MODE_MOTOR_LINE, 4'h0, 1'b1, 1'b0);
        send_cmd(MODE_SELECT_LINE, 4'h0, 1'b0, 1'b0);
        wait_responses();
    endtask

    task automatic test_random_traffic(input int send_pct, input int stall_pct,
                                       input int n_items);
        int target;
        send_idle_pct = send_pct;
        rsp_stall_pct = stall_pct;
        target        = items_sent + n_items;
        while (items_sent < target)
            random_sequence();
        wait_responses();
    endtask

    task automatic test_backpressure();
        int target;
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        hold_left     = 64;
        target        = items_sent + 40;
        while (items_sent < target)
            random_sequence();
        wait_responses();
    endtask

    initial
    begin
        rst_n               <= 1'b0;
        cmd_bus.valid       <= 1'b0;
        cmd_bus.mode        <= MODE_PHASE_WRITE;
        cmd_bus.phase_bits  <= '0;
        cmd_bus.line_level  <= 1'b0;
        cmd_bus.disk_loaded <= 1'b0;
        rsp_bus.ready       <= 1'b0;
        st_phase      = '0;
        st_motor      = 1'b0;
        st_upper_head = 1'b0;
        st_select     = 1'b0;
        st_dir_in     = 1'b1;
        st_switched   = 1'b0;
        st_track      = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_strobe_commands();
        test_eject_and_switched();
        test_select_and_heads();
        test_lines_and_unused_modes();
        test_random_traffic(0, 0, 100);
        test_random_traffic(49, 0, 100);
        test_random_traffic(0, 49, 100);
        test_random_traffic(7, 7, 100);
        test_backpressure();

        wait_responses();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && rsp_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/fdpr_pkg.sv
rtl/fdpr_cmd_if.sv
rtl/fdpr_rsp_if.sv
rtl/fdpr_engine.sv
rtl/floppy_drive_phase_register_model_unit.sv
tb/sv/floppy_drive_phase_register_model_unit_tb.sv
